### design/ptla_pkg.sv
`default_nettype none

package ptla_pkg;

  localparam int unsigned EV_W     = 24;
  localparam int unsigned POS_W    = 20;
  localparam int unsigned DIFF_W   = POS_W + 1;
  localparam int unsigned SQ_W     = 2 * DIFF_W;
  localparam int unsigned ROOT_W   = DIFF_W;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 96;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_ROOT   = 4'b0100,
    ST_DONE   = 4'b1000
  } ptla_state_e;

endpackage

`default_nettype wire

### design/ptla_sqacc.sv
`default_nettype none

module ptla_sqacc
  import ptla_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [DIFF_W-1:0] dx_i,
  input  wire logic signed [DIFF_W-1:0] dy_i,
  input  wire logic signed [DIFF_W-1:0] dz_i,
  output logic                          done_o,
  output logic [SQ_W-1:0]               sum_o
);

  localparam logic [1:0] STEP_LAST = 2'd3;

  logic signed [DIFF_W-1:0] d0_q, d1_q, d2_q;
  logic signed [SQ_W-1:0]   sq_full;
  logic [SQ_W-3:0]          prod_q;
  logic [SQ_W-1:0]          acc_q;
  logic [1:0]               step_q;
  logic                     busy_q;
  logic                     done_q;

  // One shared multiplier squares the differences as they shift past it.
  assign sq_full = d0_q * d0_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d0_q  <= dx_i;
      d1_q  <= dy_i;
      d2_q  <= dz_i;
      acc_q <= '0;
    end else if (busy_q) begin
      d0_q   <= d1_q;
      d1_q   <= d2_q;
      prod_q <= sq_full[SQ_W-3:0];
      if (step_q != 2'd0) begin
        acc_q <= acc_q + {2'b00, prod_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= busy_q && (step_q == STEP_LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == STEP_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign sum_o  = acc_q;

endmodule

`default_nettype wire

### design/ptla_isqrt.sv
`default_nettype none

module ptla_isqrt
  import ptla_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SQ_W-1:0]   radicand_i,
  output logic                   done_o,
  output logic [ROOT_W-1:0]      root_o
);

  localparam int unsigned REM_W = ROOT_W + 3;
  localparam int unsigned CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

  logic [SQ_W-1:0]   rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // Restoring square root: one result bit per cycle, two radicand bits consumed.
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
      rem_q  <= fits ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

### design/primary_track_length_accumulator_core.sv
// A non-primary hit, and the first hit of a run, are accepted straight from idle; a later primary
// hit passes through the squares on the shared multiplier, the bit-serial root and a finish step.
// Each result is held in an output register; while that register holds an unaccepted result
// the block waits in its finish state.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and clears the started flag,
// all positions, the event number and the path sum to zero.
`default_nettype none

module primary_track_length_accumulator_core
  import ptla_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // event_number[23:0], pos_x[43:24], pos_y[63:44], pos_z[83:64], zero pad[87:84]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // is_primary[0]
  input  wire logic                  s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // done_event[23:0], depth_range[44:24], straight_length[65:45], path_length[89:66],
  // zero pad[95:90]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o
);

  ptla_state_e state_q, state_d;

  logic                     started_q;
  logic [EV_W-1:0]          cur_ev_q;
  logic signed [POS_W-1:0]  first_x_q, first_y_q, first_z_q;
  logic signed [POS_W-1:0]  prev_x_q, prev_y_q, prev_z_q;
  logic [SUM_W-1:0]         path_sum_q;
  logic                     emit_q;
  logic [EV_W-1:0]          pend_ev_q;
  logic signed [DIFF_W-1:0] pend_dr_q;
  logic [SUM_W-1:0]         pend_path_q;
  logic                     m_valid_q;
  logic [OUT_DATA_W-1:0]    m_data_q;

  logic [EV_W-1:0]          in_ev;
  logic                     in_prim;
  logic signed [POS_W-1:0]  in_x, in_y, in_z;
  logic                     accept;
  logic                     first_item;
  logic                     new_event;
  logic                     start_sq;
  logic signed [POS_W-1:0]  a_x, a_y, a_z;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic                     sq_done;
  logic [SQ_W-1:0]          sq_sum;
  logic                     rt_done;
  logic [ROOT_W-1:0]        root;
  logic                     out_free;
  logic                     load_out;
  logic [SUM_W:0]           sum_wide;

  assign in_ev   = s_axis_tdata_i[EV_W-1:0];
  assign in_x    = s_axis_tdata_i[EV_W +: POS_W];
  assign in_y    = s_axis_tdata_i[EV_W + POS_W +: POS_W];
  assign in_z    = s_axis_tdata_i[EV_W + 2*POS_W +: POS_W];
  assign in_prim = s_axis_tuser_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign first_item      = !started_q;
  // The first hit seeds the event number, so it never closes an event.
  assign new_event       = !first_item && (in_ev != cur_ev_q);
  assign start_sq        = accept && in_prim && !first_item;

  // A new event measures first to previous; a step measures this hit to previous.
  assign a_x = new_event ? first_x_q : in_x;
  assign a_y = new_event ? first_y_q : in_y;
  assign a_z = new_event ? first_z_q : in_z;
  assign dx  = DIFF_W'(a_x) - DIFF_W'(prev_x_q);
  assign dy  = DIFF_W'(a_y) - DIFF_W'(prev_y_q);
  assign dz  = DIFF_W'(a_z) - DIFF_W'(prev_z_q);

  ptla_sqacc u_sqacc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_sq),
    .dx_i    (dx),
    .dy_i    (dy),
    .dz_i    (dz),
    .done_o  (sq_done),
    .sum_o   (sq_sum)
  );

  ptla_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_done),
    .radicand_i (sq_sum),
    .done_o     (rt_done),
    .root_o     (root)
  );

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign load_out = (state_q == ST_DONE) && emit_q && out_free;
  assign sum_wide = {1'b0, path_sum_q} + (SUM_W + 1)'(root);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_sq) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (sq_done) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (rt_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!emit_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      started_q  <= 1'b0;
      cur_ev_q   <= '0;
      first_x_q  <= '0;
      first_y_q  <= '0;
      first_z_q  <= '0;
      prev_x_q   <= '0;
      prev_y_q   <= '0;
      prev_z_q   <= '0;
      path_sum_q <= '0;
      emit_q     <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (accept) begin
        if (first_item) begin
          started_q <= 1'b1;
          first_x_q <= in_x;
          first_y_q <= in_y;
          first_z_q <= in_z;
        end
        if (first_item || in_prim) begin
          cur_ev_q <= in_ev;
        end
        if (in_prim) begin
          prev_x_q <= in_x;
          prev_y_q <= in_y;
          prev_z_q <= in_z;
          emit_q   <= new_event;
          if (new_event) begin
            first_x_q  <= in_x;
            first_y_q  <= in_y;
            first_z_q  <= in_z;
            path_sum_q <= '0;
          end
        end
      end

      if ((state_q == ST_DONE) && !emit_q) begin
        path_sum_q <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      end

      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // The closing event's figures are captured before the state moves to the new hit.
  always_ff @(posedge clk_i) begin
    if (accept && in_prim && new_event) begin
      pend_ev_q   <= cur_ev_q;
      pend_dr_q   <= DIFF_W'(prev_z_q) - DIFF_W'(first_z_q);
      pend_path_q <= path_sum_q;
    end
    if (load_out) begin
      m_data_q <= {(OUT_DATA_W - EV_W - DIFF_W - ROOT_W - SUM_W)'(0),
                   pend_path_q, root, pend_dr_q, pend_ev_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_sq_done_in_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == ST_SQUARE))
    else $error("square unit finished outside the square phase");

  a_rt_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_done |-> (state_q == ST_ROOT))
    else $error("root unit finished outside the root phase");

  a_path_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && !emit_q) |=> (path_sum_q >= $past(path_sum_q)))
    else $error("path sum decreased on a step update");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result presented without a finished event");

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb;
  import ptla_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_HITS = 680;
  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [EV_W-1:0]  EV_LAST = {EV_W{1'b1}};

  typedef struct {
    logic [EV_W-1:0]   done_event;
    logic [DIFF_W-1:0] depth_range;
    logic [ROOT_W-1:0] straight_length;
    logic [SUM_W-1:0]  path_length;
  } track_result_t;

  typedef struct {
    logic [EV_W-1:0]  ev;
    logic             prim;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic             typed;
    track_result_t    want;
  } hit_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_valid = 1'b0;
  logic [IN_DATA_W-1:0] s_data = '0;
  logic s_user = 1'b0;
  logic m_ready = 1'b0;
  wire logic s_ready;
  wire logic m_valid;
  wire logic [OUT_DATA_W-1:0] m_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;

  track_result_t track_q[$];
  hit_row_t      hit_table[$];

  // Shadow copy of the tracker state.
  logic             trk_started = 1'b0;
  logic [EV_W-1:0]  trk_event = '0;
  logic [POS_W-1:0] first_x = '0, first_y = '0, first_z = '0;
  logic [POS_W-1:0] last_x = '0, last_y = '0, last_z = '0;
  logic [SUM_W-1:0] trk_path = '0;

  primary_track_length_accumulator_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #5 clk = ~clk;

  function automatic logic [ROOT_W-1:0] floor_root(input longint unsigned n);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned one;
    rem = n;
    res = 0;
    one = 64'h1 << 62;
    while (one > rem) one = one >> 2;
    while (one != 0) begin
      if (rem >= res + one) begin
        rem = rem - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res[ROOT_W-1:0];
  endfunction

  function automatic logic [ROOT_W-1:0] span(input logic [POS_W-1:0] ax, ay, az,
                                             input logic [POS_W-1:0] bx, by, bz);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'($signed(ax)) - longint'($signed(bx));
    dy = longint'($signed(ay)) - longint'($signed(by));
    dz = longint'($signed(az)) - longint'($signed(bz));
    return floor_root($unsigned(dx * dx + dy * dy + dz * dz));
  endfunction

  task automatic track_hit(input logic [EV_W-1:0] ev, input logic prim,
                           input logic [POS_W-1:0] x, y, z,
                           output logic fired, output track_result_t res);
    logic first_item;
    logic [SUM_W:0] acc;
    longint dr;
    fired = 1'b0;
    res = '{default: '0};
    first_item = !trk_started;
    if (first_item) begin
      trk_started = 1'b1;
      trk_event = ev;
      first_x = x;
      first_y = y;
      first_z = z;
    end
    if (prim) begin
      if (ev != trk_event) begin
        dr = longint'($signed(last_z)) - longint'($signed(first_z));
        res.done_event = trk_event;
        res.depth_range = dr[DIFF_W-1:0];
        res.straight_length = span(first_x, first_y, first_z, last_x, last_y, last_z);
        res.path_length = trk_path;
        fired = 1'b1;
        first_x = x;
        first_y = y;
        first_z = z;
        trk_path = '0;
      end else if (!first_item) begin
        acc = {1'b0, trk_path} + (SUM_W+1)'(span(x, y, z, last_x, last_y, last_z));
        trk_path = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
      end
      last_x = x;
      last_y = y;
      last_z = z;
      trk_event = ev;
    end
  endtask

  task automatic add_row(input logic [EV_W-1:0] ev, input logic prim,
                         input logic [POS_W-1:0] x, y, z, input logic typed,
                         input logic [EV_W-1:0] done_ev, input logic [DIFF_W-1:0] dr,
                         input logic [ROOT_W-1:0] st, input logic [SUM_W-1:0] path);
    hit_row_t r;
    r.ev = ev;
    r.prim = prim;
    r.x = x;
    r.y = y;
    r.z = z;
    r.typed = typed;
    r.want.done_event = done_ev;
    r.want.depth_range = dr;
    r.want.straight_length = st;
    r.want.path_length = path;
    hit_table.push_back(r);
  endtask

  // Drives one hit and holds it until the transaction completes.
  task automatic send_hit(input logic [EV_W-1:0] ev, input logic prim,
                          input logic [POS_W-1:0] x, y, z,
                          input logic typed, input track_result_t want);
    logic fired;
    track_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user <= prim;
    s_data <= {4'b0, z, y, x, ev};
    do @(posedge clk); while (!s_ready);
    track_hit(ev, prim, x, y, z, fired, res);
    if (typed) track_q.push_back(want);
    else if (fired) track_q.push_back(res);
  endtask

  function automatic logic [POS_W-1:0] step_coord(input logic [POS_W-1:0] p);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return p + POS_W'($urandom_range(0, 4095)) - POS_W'(2048);
    else if (pick < 92) return POS_W'($urandom());
    else if (pick < 96) return POS_MAX;
    else return POS_MIN;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got, want);
    errors++;
    $display("result %0d %s: got %0h, want %0h", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output side: random back-pressure and in-order comparison.
  always @(posedge clk) begin
    track_result_t exp_r;
    m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (rst_n && m_valid && m_ready) begin
      if (track_q.size() == 0) begin
        flag_mismatch("unexpected transaction", m_data[31:0], 32'h0);
      end else begin
        exp_r = track_q.pop_front();
        if (m_data[23:0] != exp_r.done_event)
          flag_mismatch("done_event", 32'(m_data[23:0]), 32'(exp_r.done_event));
        if (m_data[44:24] != exp_r.depth_range)
          flag_mismatch("depth_range", 32'(m_data[44:24]), 32'(exp_r.depth_range));
        if (m_data[65:45] != exp_r.straight_length)
          flag_mismatch("straight_length", 32'(m_data[65:45]),
                        32'(exp_r.straight_length));
        if (m_data[89:66] != exp_r.path_length)
          flag_mismatch("path_length", 32'(m_data[89:66]), 32'(exp_r.path_length));
      end
      results_seen <= results_seen + 1;
    end
  end

  initial begin
    track_result_t none;
    logic [EV_W-1:0] walk_event;
    logic [POS_W-1:0] wx, wy, wz;
    int prim_sent;
    int run_len;
    int unsigned pick;
    none = '{default: '0};
    prim_sent = 0;

    // The first hit is not primary, so the first step is measured from the origin.
    add_row(24'd5, 1'b0, 20'd100, 20'd200, 20'd300, 1'b0, '0, '0, '0, '0);
    add_row(24'd5, 1'b1, 20'd100, 20'd200, 20'd300, 1'b0, '0, '0, '0, '0);
    add_row(24'd5, 1'b1, 20'd400, 20'd600, 20'd300, 1'b0, '0, '0, '0, '0);
    add_row(24'd6, 1'b1, 20'd0, 20'd0, 20'd0, 1'b1, 24'd5, 21'd0, 21'd500, 24'd874);
    add_row(24'd7, 1'b0, POS_MAX, POS_MIN, POS_MAX, 1'b0, '0, '0, '0, '0);
    add_row(24'd6, 1'b1, 20'd0, 20'd0, 20'd0, 1'b0, '0, '0, '0, '0);
    add_row(24'd6, 1'b1, POS_MAX, POS_MAX, POS_MAX, 1'b0, '0, '0, '0, '0);
    add_row(24'd6, 1'b1, POS_MIN, POS_MIN, POS_MIN, 1'b0, '0, '0, '0, '0);
    add_row(EV_LAST, 1'b1, POS_MIN, POS_MIN, POS_MIN, 1'b0, '0, '0, '0, '0);
    add_row(EV_LAST, 1'b1, POS_MAX, POS_MAX, POS_MAX, 1'b0, '0, '0, '0, '0);
    add_row(24'd0, 1'b1, POS_MAX, POS_MAX, POS_MAX, 1'b0, '0, '0, '0, '0);
    // Ten full-diagonal steps push the path sum past its ceiling.
    for (int i = 0; i < 5; i++) begin
      add_row(24'd0, 1'b1, POS_MIN, POS_MIN, POS_MIN, 1'b0, '0, '0, '0, '0);
      add_row(24'd0, 1'b1, POS_MAX, POS_MAX, POS_MAX, 1'b0, '0, '0, '0, '0);
    end
    add_row(24'd1, 1'b1, 20'd0, 20'd0, 20'd0, 1'b1, 24'd0, 21'd0, 21'd0, SUM_MAX);
    add_row(24'h5A5A5A, 1'b0, 20'hA5A5A, 20'h5A5A5, 20'hFFFFF, 1'b0, '0, '0, '0, '0);

    send_idle_pct = 36;
    recv_idle_pct = 47;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (hit_table[i])
      send_hit(hit_table[i].ev, hit_table[i].prim, hit_table[i].x, hit_table[i].y,
               hit_table[i].z, hit_table[i].typed, hit_table[i].want);

    // Let the pipeline drain completely before the random traffic starts.
    s_valid <= 1'b0;
    do @(posedge clk); while (track_q.size() != 0);

    walk_event = 24'd1;
    wx = '0;
    wy = '0;
    wz = '0;
    while (prim_sent < RANDOM_HITS) begin
      if (prim_sent >= 455) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (prim_sent >= 225) begin
        send_idle_pct = 47;
        recv_idle_pct = 36;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) walk_event = walk_event + EV_W'(1);
      else if (pick < 80) walk_event = EV_W'($urandom());
      else if (pick < 88) walk_event = '0;
      else if (pick < 96) walk_event = EV_LAST;
      run_len = $urandom_range(1, 8);
      for (int h = 0; h < run_len; h++) begin
        if ($urandom_range(0, 99) < 20) begin
          if ($urandom_range(0, 1) == 0)
            send_hit(EV_W'($urandom()), 1'b0, POS_W'($urandom()), POS_W'($urandom()),
                     POS_W'($urandom()), 1'b0, none);
          else
            send_hit(walk_event, 1'b0, step_coord(wx), step_coord(wy), step_coord(wz),
                     1'b0, none);
        end
        wx = step_coord(wx);
        wy = step_coord(wy);
        wz = step_coord(wz);
        send_hit(walk_event, 1'b1, wx, wy, wz, 1'b0, none);
        prim_sent++;
      end
    end
    s_valid <= 1'b0;

    while (track_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
